// ===== rtl/core/esfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package esfr_pkg;

  localparam logic [7:0] SOF_BYTE  = 8'h01;
  localparam logic [7:0] ESC_BYTE  = 8'h02;
  localparam logic [7:0] EOF_BYTE  = 8'h03;
  localparam logic [7:0] ESC_MASK  = 8'h10;
  localparam logic [2:0] HDR_LEN   = 3'd4;
  localparam logic [2:0] MIN_FRAME = 3'd5;
  localparam logic [2:0] MAX_FRAME = 3'd6;
  localparam logic [7:0] CMD_RESET = 8'h11;
  localparam logic [7:0] CMD_ERASE = 8'h12;

  typedef enum logic [1:0] {
    ACT_RESET = 2'd0,
    ACT_ERASE = 2'd1,
    ACT_OTHER = 2'd2
  } action_t;

  // one decoded frame result
  typedef struct packed {
    logic       valid;
    logic [7:0] command_code;
    action_t    action;
  } result_t;

  function automatic action_t classify(input logic [7:0] cmd);
    action_t a;
    case (cmd)
      CMD_RESET: a = ACT_RESET;
      CMD_ERASE: a = ACT_ERASE;
      default:   a = ACT_OTHER;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/esfr_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module esfr_deframer (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    fire,
  input  wire [7:0]              rx_byte,
  output esfr_pkg::result_t      result
);

  logic       frame_idle, frame_idle_next;
  logic [2:0] byte_count, byte_count_next;
  logic [7:0] running_xor, running_xor_next;
  logic       escape_pending, escape_pending_next;
  logic [7:0] header_store [4];
  logic       hdr_we;
  logic [7:0] decoded;
  logic [7:0] payload_len;
  logic       frame_ok;

  assign decoded     = escape_pending ? (rx_byte ^ esfr_pkg::ESC_MASK) : rx_byte;
  assign payload_len = {5'd0, byte_count} - {5'd0, esfr_pkg::MIN_FRAME};

  assign frame_ok = !escape_pending
                 && (byte_count >= esfr_pkg::MIN_FRAME)
                 && (running_xor == 8'd0)
                 && (header_store[0] == 8'd0)
                 && (header_store[2] == 8'd0)
                 && (header_store[3] == payload_len);

  always_comb begin
    frame_idle_next     = frame_idle;
    byte_count_next     = byte_count;
    running_xor_next    = running_xor;
    escape_pending_next = escape_pending;
    hdr_we              = 1'b0;
    result.valid        = 1'b0;
    result.command_code = header_store[1];
    result.action       = esfr_pkg::classify(header_store[1]);
    if (rx_byte == esfr_pkg::SOF_BYTE) begin
      frame_idle_next     = 1'b0;
      byte_count_next     = 3'd0;
      running_xor_next    = 8'd0;
      escape_pending_next = 1'b0;
    end else if (!frame_idle) begin
      if (rx_byte == esfr_pkg::EOF_BYTE) begin
        result.valid        = frame_ok;
        frame_idle_next     = 1'b1;
        escape_pending_next = 1'b0;
      end else if (rx_byte == esfr_pkg::ESC_BYTE) begin
        escape_pending_next = 1'b1;
      end else begin
        escape_pending_next = 1'b0;
        if (byte_count >= esfr_pkg::MAX_FRAME) begin
          // frame too long, drop it
          frame_idle_next = 1'b1;
        end else begin
          hdr_we           = (byte_count < esfr_pkg::HDR_LEN);
          running_xor_next = running_xor ^ decoded;
          byte_count_next  = byte_count + 3'd1;
        end
      end
    end
    if (!fire) begin
      result.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_idle     <= 1'b1;
      byte_count     <= 3'd0;
      running_xor    <= 8'd0;
      escape_pending <= 1'b0;
    end else if (fire) begin
      frame_idle     <= frame_idle_next;
      byte_count     <= byte_count_next;
      running_xor    <= running_xor_next;
      escape_pending <= escape_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && hdr_we) begin
      header_store[byte_count[1:0]] <= decoded;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/esfr_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module esfr_out_reg (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    load,
  input  esfr_pkg::result_t      result,
  input  wire                    taken,
  output logic                   valid,
  output logic [7:0]             command_code,
  output esfr_pkg::action_t      action
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= result.valid;
    end else if (taken) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && result.valid) begin
      command_code <= result.command_code;
      action       <= result.action;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/escaped_serial_frame_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  tdata                 tuser        tlast
// s_axis    in   [7:0] rx_byte         -            -
// m_axis    out  [7:0] command_code    [1:0] action -
//
// one word per cycle sustained while m_axis is not stalled: a received byte
// is registered in the input stage, then decoded against the frame state once
// the result slot is free, and the outcome is registered in the result register
// rst is synchronous and active high: no frame open, counters cleared
// a stalled m_axis holds one result; the input stage still takes one more word
// if it is empty, and then s_axis_tready drops until the result is taken

module escaped_serial_frame_receiver (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire  [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] command_code
  output logic [1:0] m_axis_tuser    // [1:0] action
);

  // input stage
  logic       stg_valid;
  logic [7:0] stg_byte;
  logic       proc_fire;

  esfr_pkg::result_t result;
  esfr_pkg::action_t out_action;

  // decode advances whenever a word is staged and the result slot is free or draining
  assign proc_fire     = stg_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !stg_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (s_axis_tready) begin
      stg_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      stg_byte <= s_axis_tdata;
    end
  end

  // frame state machine and header capture
  esfr_deframer u_deframer (
    .clk     (clk),
    .rst     (rst),
    .fire    (proc_fire),
    .rx_byte (stg_byte),
    .result  (result)
  );

  // result register
  esfr_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (proc_fire),
    .result       (result),
    .taken        (m_axis_tready),
    .valid        (m_axis_tvalid),
    .command_code (m_axis_tdata),
    .action       (out_action)
  );

  assign m_axis_tuser = out_action;

`ifndef SYNTHESIS
  // a new result only appears after a decode step
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(proc_fire))
    else $error("result appeared without a decode step");

  // reset and erase action classes agree with the command byte
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == esfr_pkg::ACT_RESET)
      |-> (m_axis_tdata == esfr_pkg::CMD_RESET))
    else $error("reset action with wrong command");

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == esfr_pkg::ACT_ERASE)
      |-> (m_axis_tdata == esfr_pkg::CMD_ERASE))
    else $error("erase action with wrong command");

  // a staged word that cannot advance is kept
  assert property (@(posedge clk) disable iff (rst)
    (stg_valid && !proc_fire) |=> (stg_valid && $stable(stg_byte)))
    else $error("staged word lost");
`endif

endmodule

`default_nettype wire
